FILE: hdl/delimited_packet_deframer_core_defines.svh
// ---------------------------------------------------------------------------
// Delimited packet deframer assertion macros
// Shared property shorthands for the deframer checker.
// ---------------------------------------------------------------------------
`ifndef DELIMITED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define DELIMITED_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/dpd_pkg.sv
// ---------------------------------------------------------------------------
// Delimited packet deframer package
// Frame layout constants, register and result codes, CRC-32 byte step.
// ---------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int SYNC_BYTES   = 8;
   localparam int KEEP_BYTES   = SYNC_BYTES - 1;
   localparam int FILL_BITS    = $clog2(HEADER_BYTES + 1);
   localparam int WIN_IDX_BITS = $clog2(HEADER_BYTES);
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
   localparam logic [31:0] MAX_PAYLOAD_RST = 32'd4096;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_DROP    = 1'b1;

   // register index, taken from paddr bit 3
   localparam logic [0:0] REG_SYNC_WORD   = 1'b0;
   localparam logic [0:0] REG_MAX_PAYLOAD = 1'b1;

   typedef logic [HEADER_BYTES-1:0][7:0] win_type;

   // CRC-32, MSB first, one byte per call
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/delimited_packet_deframer_core.sv
// ---------------------------------------------------------------------------
// Delimited packet deframer core
// Byte-stream deframer: delimiter and length header check, resync, CRC-32.
// ---------------------------------------------------------------------------
// One request byte is taken every cycle while the request side does not
// stall. Each byte is held in an input register, then handled in one pass
// (header window write, delimiter and length check with an eight-offset
// delimiter search, or a CRC-32 byte step) into the result register.
// Sustained rate is one byte per cycle; the request side stalls only while
// a byte is held and the result register holds a result that the receiver
// stalls, header bytes included. Header bytes give no result; a bad header
// gives one drop event; each payload byte gives one result, the last
// carrying the CRC verdict. Registers sit at byte 0 (sync_word, 64 bits)
// and byte 8 (max_payload, low 32 bits).
`default_nettype none

module delimited_packet_deframer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [7:0]                          req_in_byte,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_kind,
   output      logic [7:0]                          rsp_data_byte,
   output      logic                                rsp_last,
   output      logic                                rsp_crc_ok,
   output      logic [31:0]                         rsp_drop_total,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [dpd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [dpd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output      logic [dpd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output      logic                                csr_pready
);

   // configuration
   logic [63:0] sync_word_ff;
   logic [31:0] max_payload_ff;
   logic        csr_wr;
   logic [0:0]  csr_idx;

   // input stage
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        adv;

   // deframer state
   dpd_pkg::win_type                  win_ff, win_in;
   logic [dpd_pkg::FILL_BITS-1:0]     fill_ff, fill_in;
   logic                              in_payload_ff, in_payload_in;
   logic [31:0]                       bytes_left_ff, bytes_left_in;
   logic [31:0]                       header_crc_ff, header_crc_in;
   logic [31:0]                       crc_ff, crc_in;
   logic [31:0]                       drops_ff, drops_in;

   // result register
   logic        rsp_valid_ff;
   logic        kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        ok_ff, ok_in;
   logic        res_valid;

   // header evaluation
   dpd_pkg::win_type w;
   logic [31:0]      len;
   logic             bad;
   logic             found;
   logic [3:0]       sel;
   logic [31:0]      crc_step;
   logic [31:0]      left_dec;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3];

   always_comb begin
      unique case (csr_idx)
         dpd_pkg::REG_SYNC_WORD:   csr_prdata = sync_word_ff;
         dpd_pkg::REG_MAX_PAYLOAD: csr_prdata = {32'h0, max_payload_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff   <= '0;
         max_payload_ff <= dpd_pkg::MAX_PAYLOAD_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            dpd_pkg::REG_SYNC_WORD:   sync_word_ff   <= csr_pwdata;
            dpd_pkg::REG_MAX_PAYLOAD: max_payload_ff <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   // advance the held request when the result slot is free or being taken
   assign adv       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_comb begin
      w = win_ff;
      w[fill_ff[dpd_pkg::WIN_IDX_BITS-1:0]] = in_byte_ff;
      len = w[15:12];
      bad = (w[7:0] != sync_word_ff) || (len == 32'h0) || (len > max_payload_ff);
      // first matching offset wins: scan high to low so the lowest overrides
      found = 1'b0;
      sel   = 4'd0;
      for (int i = dpd_pkg::SYNC_BYTES; i >= 1; i--) begin
         if (w[i +: dpd_pkg::SYNC_BYTES] == sync_word_ff) begin
            found = 1'b1;
            sel   = 4'(i);
         end
      end
      crc_step = dpd_pkg::crc_byte(crc_ff, in_byte_ff);
      left_dec = bytes_left_ff - 32'd1;
   end

   always_comb begin
      win_in        = win_ff;
      fill_in       = fill_ff;
      in_payload_in = in_payload_ff;
      bytes_left_in = bytes_left_ff;
      header_crc_in = header_crc_ff;
      crc_in        = crc_ff;
      drops_in      = drops_ff;
      res_valid     = 1'b0;
      kind_in       = dpd_pkg::KIND_PAYLOAD;
      data_in       = 8'h0;
      last_in       = 1'b0;
      ok_in         = 1'b0;
      if (in_payload_ff) begin
         crc_in        = crc_step;
         bytes_left_in = left_dec;
         res_valid     = 1'b1;
         data_in       = in_byte_ff;
         if (left_dec == 32'h0) begin
            last_in       = 1'b1;
            ok_in         = (crc_step == header_crc_ff);
            drops_in      = (crc_step == header_crc_ff) ? drops_ff : drops_ff + 32'd1;
            in_payload_in = 1'b0;
            fill_in       = '0;
            win_in        = '0;
         end
      end else if (fill_ff != dpd_pkg::FILL_BITS'(dpd_pkg::HEADER_BYTES - 1)) begin
         win_in  = w;
         fill_in = fill_ff + dpd_pkg::FILL_BITS'(1);
      end else if (bad) begin
         drops_in  = drops_ff + 32'd1;
         res_valid = 1'b1;
         kind_in   = dpd_pkg::KIND_DROP;
         if (found) begin
            // drop the bytes ahead of the matching delimiter
            win_in  = w >> {sel, 3'b000};
            fill_in = dpd_pkg::FILL_BITS'(dpd_pkg::HEADER_BYTES) - dpd_pkg::FILL_BITS'(sel);
         end else begin
            win_in  = w >> (8 * (dpd_pkg::HEADER_BYTES - dpd_pkg::KEEP_BYTES));
            fill_in = dpd_pkg::FILL_BITS'(dpd_pkg::KEEP_BYTES);
         end
      end else begin
         header_crc_in = w[11:8];
         bytes_left_in = len;
         crc_in        = 32'h0;
         in_payload_in = 1'b1;
         fill_in       = '0;
         win_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         in_payload_ff <= 1'b0;
         drops_ff      <= '0;
         win_ff        <= '0;
      end else if (adv) begin
         fill_ff       <= fill_in;
         in_payload_ff <= in_payload_in;
         drops_ff      <= drops_in;
         win_ff        <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bytes_left_ff <= bytes_left_in;
         header_crc_ff <= header_crc_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_valid) begin
         kind_ff        <= kind_in;
         data_ff        <= data_in;
         last_ff        <= last_in;
         ok_ff          <= ok_in;
         rsp_drop_total <= drops_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_last      = last_ff;
   assign rsp_crc_ok    = ok_ff;

endmodule

`default_nettype wire

FILE: hdl/dpd_checker.sv
// ---------------------------------------------------------------------------
// Delimited packet deframer checker
// Port-level properties of the deframer result channel, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "delimited_packet_deframer_core_defines.svh"

module dpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_kind,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic        rsp_last,
   input wire logic        rsp_crc_ok,
   input wire logic [31:0] rsp_drop_total
);

   `DPD_ASSERT_NOW(a_drop_fields, clock, reset, rsp_valid && (rsp_kind == dpd_pkg::KIND_DROP), (rsp_data_byte == 8'h0) && !rsp_last && !rsp_crc_ok, "drop event with payload fields set")

   `DPD_ASSERT_NOW(a_ok_on_last, clock, reset, rsp_valid && rsp_crc_ok, rsp_last && (rsp_kind == dpd_pkg::KIND_PAYLOAD), "crc verdict outside last payload byte")

   `DPD_ASSERT_NOW(a_last_is_payload, clock, reset, rsp_valid && rsp_last, rsp_kind == dpd_pkg::KIND_PAYLOAD, "last flag on a drop event")

   `DPD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drop_total) && $stable(rsp_data_byte), "stalled result changed")

endmodule

bind delimited_packet_deframer_core dpd_checker u_dpd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_last       (rsp_last),
   .rsp_crc_ok     (rsp_crc_ok),
   .rsp_drop_total (rsp_drop_total)
);

`default_nettype wire
